// ===== rtl/climate_hysteresis_controller_macros.svh =====
// Assertion macros shared by the climate hysteresis controller modules
`ifndef CLIMATE_HYSTERESIS_CONTROLLER_MACROS_SVH
`define CLIMATE_HYSTERESIS_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chc_pkg.sv =====
// Types and constants of the climate hysteresis controller
package chc_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_TEMP_LOW        = 3'd1;
    localparam logic [2:0] REG_TEMP_HIGH       = 3'd2;
    localparam logic [2:0] REG_HUMID_LOW       = 3'd3;
    localparam logic [2:0] REG_HUMID_HIGH      = 3'd4;
    localparam logic [2:0] REG_HEAT_MAX_ON     = 3'd5;
    localparam logic [2:0] REG_COOLDOWN        = 3'd6;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_HEAT = 2'd1;
    localparam logic [1:0] MODE_COOL = 2'd2;

    localparam logic signed [12:0] TEMP_HYST  = 13'sd5;
    localparam logic signed [11:0] HUMID_HYST = 12'sd20;
    localparam logic [7:0]         LED_FULL   = 8'd255;
    localparam logic [7:0]         LED_OFF    = 8'd0;

    typedef struct packed {
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic [15:0]        light_level;
        logic [31:0]        now_ms;
    } chc_in_t;

    typedef struct packed {
        logic       relay_power;
        logic       relay_polarity;
        logic [1:0] peltier_state;
        logic       cooldown_flag;
        logic       humidifier_pulse;
        logic       humidifier_active;
        logic [7:0] led_level;
    } chc_out_t;

    typedef struct packed {
        logic [15:0]        light_threshold;
        logic signed [11:0] temp_low_limit;
        logic signed [11:0] temp_high_limit;
        logic [9:0]         humid_low_limit;
        logic [9:0]         humid_high_limit;
        logic [31:0]        heat_max_on_ms;
        logic [31:0]        cooldown_ms;
    } chc_cfg_t;

endpackage

// ===== rtl/chc_regs.sv =====
// APB configuration register file of the climate hysteresis controller
module chc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [chc_pkg::PADDR_W-1:0] paddr,
    input  logic [chc_pkg::PDATA_W-1:0] pwdata,
    output logic [chc_pkg::PDATA_W-1:0] prdata,
    output chc_pkg::chc_cfg_t           cfg
);
    import chc_pkg::*;

    chc_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx   = paddr[PADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold  <= 16'd1000;
            cfg_reg.temp_low_limit   <= 12'sd200;
            cfg_reg.temp_high_limit  <= 12'sd300;
            cfg_reg.humid_low_limit  <= 10'd600;
            cfg_reg.humid_high_limit <= 10'd900;
            cfg_reg.heat_max_on_ms   <= 32'd600000;
            cfg_reg.cooldown_ms      <= 32'd300000;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LIGHT_THRESHOLD: cfg_reg.light_threshold  <= pwdata[15:0];
                REG_TEMP_LOW:        cfg_reg.temp_low_limit   <= $signed(pwdata[11:0]);
                REG_TEMP_HIGH:       cfg_reg.temp_high_limit  <= $signed(pwdata[11:0]);
                REG_HUMID_LOW:       cfg_reg.humid_low_limit  <= pwdata[9:0];
                REG_HUMID_HIGH:      cfg_reg.humid_high_limit <= pwdata[9:0];
                REG_HEAT_MAX_ON:     cfg_reg.heat_max_on_ms   <= pwdata;
                REG_COOLDOWN:        cfg_reg.cooldown_ms      <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LIGHT_THRESHOLD: prdata = {16'd0, cfg_reg.light_threshold};
            REG_TEMP_LOW:        prdata = {20'd0, cfg_reg.temp_low_limit};
            REG_TEMP_HIGH:       prdata = {20'd0, cfg_reg.temp_high_limit};
            REG_HUMID_LOW:       prdata = {22'd0, cfg_reg.humid_low_limit};
            REG_HUMID_HIGH:      prdata = {22'd0, cfg_reg.humid_high_limit};
            REG_HEAT_MAX_ON:     prdata = cfg_reg.heat_max_on_ms;
            REG_COOLDOWN:        prdata = cfg_reg.cooldown_ms;
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/chc_step.sv =====
// Controller state and per-sample decision logic
`include "climate_hysteresis_controller_macros.svh"

module chc_step #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  chc_pkg::chc_in_t  sample,
    input  chc_pkg::chc_cfg_t cfg,
    output chc_pkg::chc_out_t res
);
    import chc_pkg::*;

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [1:0]           mode_reg, mode_next;
    logic [TIME_BITS-1:0] pstart_reg, pstart_next;
    logic                 cd_reg, cd_next;
    logic [TIME_BITS-1:0] cdstart_reg, cdstart_next;
    logic                 hum_reg, hum_next;

    logic [CMP_W-1:0]     now_w;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_heat;
    logic [TIME_BITS-1:0] el_cool;
    logic                 heat_to;
    logic [1:0]           mode_mid;
    logic                 cd_mid;
    logic signed [12:0]   temp_x, temp_lo, temp_hi;
    logic signed [11:0]   humid_x, humid_lo, humid_hi;
    logic                 too_cold, too_hot, too_dry, too_wet;
    logic                 pulse;

    assign now_w = CMP_W'(sample.now_ms);
    assign now_t = now_w[TIME_BITS-1:0];

    assign el_heat = now_t - pstart_reg;
    assign heat_to = (mode_reg == MODE_HEAT) &&
                     (CMP_W'(el_heat) >= CMP_W'(cfg.heat_max_on_ms));
    // a fresh timeout restarts the cooldown at now, so its elapsed time is zero
    assign el_cool = heat_to ? '0 : (now_t - cdstart_reg);

    assign mode_mid     = heat_to ? MODE_OFF : mode_reg;
    assign cd_mid       = heat_to || cd_reg;
    assign cdstart_next = heat_to ? now_t : cdstart_reg;
    assign cd_next      = cd_mid && (CMP_W'(el_cool) < CMP_W'(cfg.cooldown_ms));

    assign temp_x   = $signed({sample.temperature[11], sample.temperature});
    assign temp_lo  = $signed({cfg.temp_low_limit[11], cfg.temp_low_limit}) - TEMP_HYST;
    assign temp_hi  = $signed({cfg.temp_high_limit[11], cfg.temp_high_limit}) + TEMP_HYST;
    assign too_cold = temp_x < temp_lo;
    assign too_hot  = temp_x > temp_hi;

    assign humid_x  = $signed({2'b00, sample.humidity});
    assign humid_lo = $signed({2'b00, cfg.humid_low_limit}) - HUMID_HYST;
    assign humid_hi = $signed({2'b00, cfg.humid_high_limit}) + HUMID_HYST;
    assign too_dry  = humid_x < humid_lo;
    assign too_wet  = humid_x > humid_hi;

    always_comb
    begin
        mode_next   = mode_mid;
        pstart_next = pstart_reg;
        priority if (too_cold)
        begin
            if (mode_mid != MODE_HEAT && !cd_next)
            begin
                mode_next   = MODE_HEAT;
                pstart_next = now_t;
            end
        end
        else if (too_hot)
        begin
            if (mode_mid != MODE_COOL)
            begin
                mode_next   = MODE_COOL;
                pstart_next = now_t;
            end
        end
        else
        begin
            mode_next = MODE_OFF;
        end
    end

    always_comb
    begin
        pulse    = 1'b0;
        hum_next = hum_reg;
        priority if (too_dry && !hum_reg)
        begin
            pulse    = 1'b1;
            hum_next = 1'b1;
        end
        else if (too_wet && hum_reg)
        begin
            pulse    = 1'b1;
            hum_next = 1'b0;
        end
        else
        begin
            pulse    = 1'b0;
            hum_next = hum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            pstart_reg  <= '0;
            cd_reg      <= 1'b0;
            cdstart_reg <= '0;
            hum_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            pstart_reg  <= pstart_next;
            cd_reg      <= cd_next;
            cdstart_reg <= cdstart_next;
            hum_reg     <= hum_next;
        end
    end

    assign res.relay_power       = (mode_next != MODE_OFF);
    assign res.relay_polarity    = (mode_next == MODE_HEAT);
    assign res.peltier_state     = mode_next;
    assign res.cooldown_flag     = cd_next;
    assign res.humidifier_pulse  = pulse;
    assign res.humidifier_active = hum_next;
    assign res.led_level         = (sample.light_level < cfg.light_threshold) ? LED_FULL
                                                                               : LED_OFF;

    `CHC_ASSERT_NOW(a_no_heat_in_cooldown,
        advance && mode_next == MODE_HEAT && mode_reg != MODE_HEAT, !cd_next,
        "heating entered while cooldown active")
    `CHC_ASSERT_NEXT(a_start_on_entry,
        advance && mode_next != MODE_OFF && mode_next != mode_reg,
        pstart_reg == $past(now_t), "start time not taken on mode entry")
    `CHC_ASSERT_NEXT(a_pulse_flips,
        advance && pulse, hum_reg != $past(hum_reg),
        "humidifier pulse without state flip")

endmodule

// ===== rtl/climate_hysteresis_controller.sv =====
// Top level of the climate hysteresis controller: word registers and handshake
//
// Usage:
//   Sample channel (sample_valid/sample_ready/sample): one sensor word per
//   transfer with temperature, humidity, light level and a ms timestamp.
//   Result channel (result_valid/result_ready/result): one word per sample
//   with relay drives, Peltier mode, cooldown flag, humidifier pulse and
//   state, and LED level.
//   APB port: seven registers at byte addresses 0, 4, ... 24; pready is
//   always high, reads return the stored value. Write only while idle.
// Order: a sample taken is held in the input register and its result is
//   registered in the result register once that register is free.
// Throughput: one word per cycle while results are taken, set by the single
//   decision pass between the input register and the result register.
// Reset: the decision state clears, registers take their defaults, both channels
//   come up empty.
// Stall: a held result keeps its value; one more sample waits in the input
//   register, then sample_ready drops until the result is taken.
`include "climate_hysteresis_controller_macros.svh"

module climate_hysteresis_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  chc_pkg::chc_in_t            sample,
    output logic                        result_valid,
    input  logic                        result_ready,
    output chc_pkg::chc_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [chc_pkg::PADDR_W-1:0] paddr,
    input  logic [chc_pkg::PDATA_W-1:0] pwdata,
    output logic [chc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import chc_pkg::*;

    chc_cfg_t cfg;
    chc_in_t  in_reg;
    logic     in_valid_reg;
    chc_out_t out_reg, out_next;
    logic     out_valid_reg;
    logic     advance;

    assign pready       = 1'b1;
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    chc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    chc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_reg),
        .cfg     (cfg),
        .res     (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_reg <= sample;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    `CHC_ASSERT_NOW(a_polarity_heat,
        out_valid_reg && out_reg.relay_polarity,
        out_reg.relay_power && out_reg.peltier_state == MODE_HEAT,
        "polarity relay set outside heating")
    `CHC_ASSERT_NOW(a_led_levels,
        out_valid_reg, out_reg.led_level == LED_FULL || out_reg.led_level == LED_OFF,
        "LED level not full or off")
    `CHC_ASSERT_NEXT(a_input_held,
        in_valid_reg && out_valid_reg && !result_ready,
        in_valid_reg && $stable(in_reg), "waiting sample lost during stall")

endmodule

// ===== verif/tb_climate_hysteresis_controller.sv =====
// Self-checking testbench for the climate hysteresis controller: random and directed sensor words
module tb_climate_hysteresis_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import chc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    chc_in_t             sample = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    chc_out_t            result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predictor state and register copy
    chc_cfg_t            cfg;
    logic [1:0]          pel_mode;
    logic [31:0]         pel_since;
    logic                blk_active;
    logic [31:0]         blk_since;
    logic                humid_on;

    chc_in_t             sensor_words[$];
    chc_out_t            predicted_results[$];

    logic                calm = 1'b0;
    int unsigned         time_span;
    logic [31:0]         stamp_ms = '0;
    int                  temp_zone = 0;
    int                  n_fail = 0;
    int                  n_checked = 0;
    int                  n_pulses = 0;
    int                  n_timeouts = 0;
    int                  n_settings = 1;
    int                  cycle_cnt = 0;

    climate_hysteresis_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int tenths(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic chc_out_t predict_climate(chc_in_t s);
        chc_out_t    r;
        logic [31:0] since;
        int          t;
        int          h;
        logic        pulse;
        t = tenths(s.temperature);
        h = {22'd0, s.humidity};
        pulse = 1'b0;
        since = s.now_ms - pel_since;
        if (pel_mode == MODE_HEAT && since >= cfg.heat_max_on_ms)
        begin
            pel_mode = MODE_OFF;
            blk_active = 1'b1;
            blk_since = s.now_ms;
            n_timeouts++;
        end
        since = s.now_ms - blk_since;
        if (blk_active && since >= cfg.cooldown_ms)
            blk_active = 1'b0;
        if (t < tenths(cfg.temp_low_limit) - 5)
        begin
            if (pel_mode != MODE_HEAT && !blk_active)
            begin
                pel_mode = MODE_HEAT;
                pel_since = s.now_ms;
            end
        end
        else if (t > tenths(cfg.temp_high_limit) + 5)
        begin
            if (pel_mode != MODE_COOL)
            begin
                pel_mode = MODE_COOL;
                pel_since = s.now_ms;
            end
        end
        else
            pel_mode = MODE_OFF;
        if (h < int'({22'd0, cfg.humid_low_limit}) - 20 && !humid_on)
        begin
            pulse = 1'b1;
            humid_on = 1'b1;
        end
        else if (h > int'({22'd0, cfg.humid_high_limit}) + 20 && humid_on)
        begin
            pulse = 1'b1;
            humid_on = 1'b0;
        end
        if (pulse)
            n_pulses++;
        r.relay_power       = (pel_mode != MODE_OFF);
        r.relay_polarity    = (pel_mode == MODE_HEAT);
        r.peltier_state     = pel_mode;
        r.cooldown_flag     = blk_active;
        r.humidifier_pulse  = pulse;
        r.humidifier_active = humid_on;
        r.led_level         = (s.light_level < cfg.light_threshold) ? LED_FULL : LED_OFF;
        return r;
    endfunction

    // sticky temperature zones let heating run long enough to hit its time limit
    function automatic chc_in_t random_sample();
        chc_in_t s;
        int      pick;
        int      lim;
        if ($urandom_range(0, 99) < 15)
            temp_zone = $urandom_range(0, 3);
        case (temp_zone)
            0: s.temperature = 12'(tenths(cfg.temp_low_limit) + 2 - int'($urandom_range(0, 32)));
            2: s.temperature = 12'(tenths(cfg.temp_high_limit) - 2 + int'($urandom_range(0, 32)));
            1:
            begin
                lim = $urandom_range(0, 1) ? tenths(cfg.temp_low_limit)
                                           : tenths(cfg.temp_high_limit);
                s.temperature = 12'(lim + int'($urandom_range(0, 20)) - 10);
            end
            default:
                s.temperature = $urandom_range(0, 1) ? 12'($urandom)
                                                     : 12'(int'($urandom_range(0, 1650)) - 400);
        endcase
        pick = $urandom_range(0, 99);
        lim = $urandom_range(0, 1) ? int'({22'd0, cfg.humid_low_limit})
                                   : int'({22'd0, cfg.humid_high_limit});
        if (pick < 70)
            s.humidity = 10'(lim + int'($urandom_range(0, 50)) - 25);
        else if (pick < 85)
            s.humidity = 10'($urandom_range(0, 1000));
        else
            s.humidity = 10'($urandom);
        if ($urandom_range(0, 1))
            s.light_level = 16'(int'({16'd0, cfg.light_threshold}) + int'($urandom_range(0, 6)) - 3);
        else
            s.light_level = 16'($urandom);
        if ($urandom_range(0, 99) < 8)
            stamp_ms = $urandom;
        else
            stamp_ms = stamp_ms + $urandom_range(0, time_span);
        s.now_ms = stamp_ms;
        return s;
    endfunction

    task automatic add_word(int t, int h, int l, logic [31:0] now);
        chc_in_t s;
        s.temperature = 12'(t);
        s.humidity    = 10'(h);
        s.light_level = 16'(l);
        s.now_ms      = now;
        sensor_words.push_back(s);
    endtask

    task automatic add_random(int n, int unsigned span);
        time_span = span;
        repeat (n) sensor_words.push_back(random_sample());
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LIGHT_THRESHOLD: cfg.light_threshold  = value[15:0];
            REG_TEMP_LOW:        cfg.temp_low_limit   = value[11:0];
            REG_TEMP_HIGH:       cfg.temp_high_limit  = value[11:0];
            REG_HUMID_LOW:       cfg.humid_low_limit  = value[9:0];
            REG_HUMID_HIGH:      cfg.humid_high_limit = value[9:0];
            REG_HEAT_MAX_ON:     cfg.heat_max_on_ms   = value;
            REG_COOLDOWN:        cfg.cooldown_ms      = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] light, logic [31:0] tlo, logic [31:0] thi,
                              logic [31:0] hlo, logic [31:0] hhi,
                              logic [31:0] heat, logic [31:0] cool);
        write_reg(REG_LIGHT_THRESHOLD, light);
        write_reg(REG_TEMP_LOW, tlo);
        write_reg(REG_TEMP_HIGH, thi);
        write_reg(REG_HUMID_LOW, hlo);
        write_reg(REG_HUMID_HIGH, hhi);
        write_reg(REG_HEAT_MAX_ON, heat);
        write_reg(REG_COOLDOWN, cool);
        n_settings++;
        @(negedge clk);
    endtask

    // sender holds off until every predicted word is back, then the pipe settles
    task automatic drain();
        @(negedge clk);
        while (sensor_words.size() != 0 || sample_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                predicted_results.push_back(predict_climate(sample));
            if (!sample_valid || sample_ready)
            begin
                if (sensor_words.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    sample       <= sensor_words.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        chc_out_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    n_fail++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("relay_power", want.relay_power, result.relay_power);
                    check_field("relay_polarity", want.relay_polarity, result.relay_polarity);
                    check_field("peltier_state", want.peltier_state, result.peltier_state);
                    check_field("cooldown_flag", want.cooldown_flag, result.cooldown_flag);
                    check_field("humidifier_pulse", want.humidifier_pulse,
                                result.humidifier_pulse);
                    check_field("humidifier_active", want.humidifier_active,
                                result.humidifier_active);
                    check_field("led_level", want.led_level, result.led_level);
                    n_checked++;
                end
            end
            result_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        cfg.light_threshold  = 16'd1000;
        cfg.temp_low_limit   = 12'd200;
        cfg.temp_high_limit  = 12'd300;
        cfg.humid_low_limit  = 10'd600;
        cfg.humid_high_limit = 10'd900;
        cfg.heat_max_on_ms   = 32'd600000;
        cfg.cooldown_ms      = 32'd300000;
        pel_mode   = MODE_OFF;
        pel_since  = '0;
        blk_active = 1'b0;
        blk_since  = '0;
        humid_on   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: heat, timeout, cooldown expiry, wrap, band edges, led edge
        add_word(100, 500, 999, 32'd1000);
        add_word(100, 500, 1000, 32'd600999);
        add_word(100, 1023, 0, 32'd601000);
        add_word(-2048, 0, 65535, 32'd900999);
        add_word(-400, 1000, 0, 32'd901000);
        add_word(2047, 0, 65535, 32'd901001);
        add_word(1250, 579, 0, 32'd0);
        add_word(250, 900, 0, 32'hFFFF_FFFF);
        add_word(194, 921, 12345, 32'hFFFF_FF00);
        add_word(194, 580, 54321, 32'h0009_2000);
        add_word(195, 579, 1, 32'h0009_2800);
        add_word(306, 920, 2, 32'h0009_2801);
        add_word(305, 0, 3, 32'h0009_2802);
        drain();
        add_random(150, 200000);
        drain();

        // zero times: timeout and cooldown both end within one word
        set_config(0, -400, 1250, 0, 1000, 0, 0);
        add_word(-2048, 1023, 0, 32'd5);
        add_word(-2048, 0, 65535, 32'd5);
        add_word(-406, 1023, 0, 32'd6);
        add_random(150, 3);
        drain();

        // inverted limits, longest times: heat wins, blocked heat keeps mode
        set_config(65535, 1250, -400, 1000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(1250, 500, 65535, 32'd50);
        add_word(500, 500, 65534, 32'd100);
        add_word(500, 500, 0, 32'd99);
        add_word(500, 500, 0, 32'd98);
        add_random(150, 1000);
        drain();

        // short times with no idling on either side
        calm = 1'b1;
        set_config(30000, 150, 250, 300, 700, 5000, 3000);
        add_random(150, 2500);
        drain();
        calm = 1'b0;

        set_config($urandom_range(0, 65535), int'($urandom_range(0, 1650)) - 400,
                   int'($urandom_range(0, 1650)) - 400, $urandom_range(0, 1000),
                   $urandom_range(0, 1000), $urandom_range(0, 20000), $urandom_range(0, 20000));
        add_random(150, 6000);
        drain();

        // limits outside their stated ranges
        set_config(32'h0000_1234, 2047, -2048, 1023, 1023, 1, 2);
        add_random(150, 4);
        drain();

        $display("%0d result words checked over %0d register settings", n_checked, n_settings);
        $display("%0d humidifier pulses and %0d heating timeouts predicted", n_pulses, n_timeouts);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
